[hw/rtl/hop_limited_reachability_defines.svh]
// Assertion macros shared by the reachability block.
`ifndef HOP_LIMITED_REACHABILITY_DEFINES_SVH
`define HOP_LIMITED_REACHABILITY_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define HLR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the following cycle.
`define HLR_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hlr_pkg.sv]
package hlr_pkg;

    localparam int NODE_W  = 6;
    localparam int LIMIT_W = 16;
    localparam int MASK_W  = 64;
    localparam int COUNT_W = 7;

    localparam logic FUNC_STOP  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [NODE_W-1:0]  node;
        logic               line_start;
        logic [LIMIT_W-1:0] hop_limit;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0]  reached_mask;
        logic [COUNT_W-1:0] reached_count;
    } t_rsp;

    // Undirected link request broadcast to every row cell.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
    } t_link;

endpackage

[hw/rtl/hlr_if.sv]
interface hlr_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/hlr_cell.sv]
module hlr_cell #(
    parameter int NODES = 64,
    parameter int INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hlr_pkg::t_link i_link,
    input  logic [NODES-1:0] i_frontier,
    output logic           o_hit
);
    import hlr_pkg::*;

    localparam int IDX_W = $clog2(NODES);

    logic [NODES-1:0] r_row;
    logic [NODES-1:0] n_row;

    // The matrix is symmetric, so this row also serves as this node's column.
    always_comb begin
        n_row = r_row;
        if (i_link.valid) begin
            if (i_link.a == NODE_W'(INDEX)) begin
                n_row[i_link.b[IDX_W-1:0]] = 1'b1;
            end
            if (i_link.b == NODE_W'(INDEX)) begin
                n_row[i_link.a[IDX_W-1:0]] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_hit = |(r_row & i_frontier);

endmodule

[hw/rtl/hop_limited_reachability.sv]
// Hop-limited reachability over an undirected graph of up to NODES nodes.
// Requests arrive on i_in (valid/ready, payload t_req) and results leave on
// o_out (valid/ready, payload t_rsp). A stop request adds a node to the
// current line and links it both ways with the previous stop unless it opens
// a new line; it gives no result. A query request gives a source and a hop
// limit and returns the mask and count of reachable nodes. Each node row
// lives in its own cell; one hop level is expanded per cycle, ending early
// once the frontier empties or the hop limit, capped at NODES-1, is used
// up; the input is not ready while a query expands. The result then sits
// in an output register while the next request is accepted. If the
// receiver stalls with a result still held, a finished query waits in
// place and the input stays blocked until the register frees. Reset clears
// all links and the previous stop; the block takes requests in the first
// cycle after it.
module hop_limited_reachability #(
    parameter int NODES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hlr_if.sink   i_in,
    hlr_if.source o_out
);
    import hlr_pkg::*;

    localparam int LVL_W = $clog2(NODES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic               r_state;
    logic               n_state;
    logic [NODE_W-1:0]  r_prev;
    logic               r_prev_valid;
    logic [MASK_W-1:0]  r_reached;
    logic [NODES-1:0]   r_frontier;
    logic [LVL_W-1:0]   r_left;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    t_rsp               r_out;

    t_req               w_req;
    logic               w_accept;
    logic               w_in_range;
    logic               w_done;
    logic               w_load;
    logic [NODES-1:0]   w_hits;
    logic [NODES-1:0]   w_next;
    t_link              w_link;

    assign w_req      = i_in.payload;
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_range = ({1'b0, w_req.node} < (NODE_W + 1)'(NODES));

    assign w_link.valid = w_accept && (w_req.func == FUNC_STOP) && w_in_range
                          && !w_req.line_start && r_prev_valid;
    assign w_link.a     = w_req.node;
    assign w_link.b     = r_prev;

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        hlr_cell #(
            .NODES (NODES),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_link     (w_link),
            .i_frontier (r_frontier),
            .o_hit      (w_hits[g])
        );
    end

    assign w_next = w_hits & ~r_reached[NODES-1:0];
    assign w_done = (r_left == '0) || (r_frontier == '0);
    assign w_load = (r_state == ST_RUN) && w_done && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_req.func == FUNC_QUERY)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_frontier   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept && (w_req.func == FUNC_STOP)) begin
                r_prev_valid <= w_in_range;
                if (w_in_range) begin
                    r_prev <= w_req.node;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept && (w_req.func == FUNC_QUERY)) begin
                r_frontier <= NODES'(w_in_range) << w_req.node[LVL_W-1:0];
            end else if ((r_state == ST_RUN) && !w_done) begin
                r_frontier <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_req.func == FUNC_QUERY)) begin
            r_reached <= MASK_W'(1) << w_req.node;
            r_count   <= COUNT_W'(1);
            if (!w_in_range) begin
                r_left <= '0;
            end else if (w_req.hop_limit >= LIMIT_W'(NODES - 1)) begin
                r_left <= LVL_W'(NODES - 1);
            end else begin
                r_left <= w_req.hop_limit[LVL_W-1:0];
            end
        end else if ((r_state == ST_RUN) && !w_done) begin
            r_reached <= r_reached | MASK_W'(w_next);
            r_count   <= r_count + COUNT_W'($countones(w_next));
            r_left    <= r_left - LVL_W'(1);
        end
        if (w_load) begin
            r_out.reached_mask  <= r_reached;
            r_out.reached_count <= r_count;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

`include "hop_limited_reachability_defines.svh"

    `HLR_ASSERT_ALWAYS(a_count_matches_mask, !o_out.valid || (o_out.payload.reached_count == COUNT_W'($countones(o_out.payload.reached_mask))), "result count disagrees with mask")
    `HLR_ASSERT_ALWAYS(a_source_reached, !o_out.valid || (o_out.payload.reached_count != '0), "result reaches no node")
    `HLR_ASSERT_ALWAYS(a_frontier_in_reached, (r_state != ST_RUN) || ((r_frontier & ~r_reached[NODES-1:0]) == '0), "frontier holds an unreached node")
    `HLR_ASSERT_NEXT(a_query_starts, w_accept && (w_req.func == FUNC_QUERY), r_state == ST_RUN, "accepted query did not start expansion")

endmodule

[bench/tb_hop_limited_reachability.sv]
`timescale 1ns / 100ps

module tb_hop_limited_reachability;
    import hlr_pkg::*;

    localparam int NODES = 64;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp answer;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    hlr_if #(.t_payload(t_req)) req_if ();
    hlr_if #(.t_payload(t_rsp)) rsp_if ();

    hop_limited_reachability #(
        .NODES(NODES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    logic [MASK_W-1:0] link_rows [NODES];
    logic [NODE_W-1:0] last_stop;
    bit                last_stop_valid;
    t_rsp              pending_answers [$];
    t_rsp              oldest_answer;
    int                errors;
    int                sent;
    int                burst_left;
    bit                hold_off_req;

    t_script_row script [19] = '{
        '{'{FUNC_QUERY, 6'd0, 1'b0, 16'd0}, 1'b1, '{64'd1, 7'd1}},
        '{'{FUNC_QUERY, 6'd63, 1'b0, 16'hFFFF}, 1'b1, '{64'h8000_0000_0000_0000, 7'd1}},
        '{'{FUNC_STOP, 6'd0, 1'b1, 16'd0}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_STOP, 6'd1, 1'b0, 16'd0}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_STOP, 6'd2, 1'b0, 16'd0}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_STOP, 6'd2, 1'b0, 16'd0}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_STOP, 6'd63, 1'b0, 16'd0}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_QUERY, 6'd0, 1'b0, 16'd0}, 1'b1, '{64'd1, 7'd1}},
        '{'{FUNC_QUERY, 6'd0, 1'b0, 16'd1}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_QUERY, 6'd2, 1'b0, 16'd1}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_QUERY, 6'd0, 1'b0, 16'd62}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_QUERY, 6'd0, 1'b0, 16'd63}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_STOP, 6'd40, 1'b1, 16'hFFFF}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_STOP, 6'd41, 1'b0, 16'h5A5A}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_STOP, 6'd0, 1'b0, 16'hA5A5}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_QUERY, 6'd40, 1'b1, 16'hFFFF}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_QUERY, 6'd20, 1'b0, 16'd5}, 1'b1, '{64'h0000_0000_0010_0000, 7'd1}},
        '{'{FUNC_QUERY, 6'd63, 1'b1, 16'd2}, 1'b0, '{64'd0, 7'd0}},
        '{'{FUNC_QUERY, 6'd41, 1'b0, 16'd64}, 1'b0, '{64'd0, 7'd0}}
    };

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_rsp reach_within(logic [NODE_W-1:0] src, logic [LIMIT_W-1:0] limit);
        logic [MASK_W-1:0] seen;
        logic [MASK_W-1:0] front;
        logic [MASK_W-1:0] grown;
        int                levels;
        t_rsp              ans;
        seen = 64'd1 << src;
        front = seen;
        levels = (limit > NODES - 1) ? NODES - 1 : int'(limit);
        if (src >= NODES) begin
            levels = 0;
        end
        for (int k = 0; k < levels && front != '0; k++) begin
            grown = '0;
            for (int i = 0; i < NODES; i++) begin
                if (front[i]) begin
                    grown |= link_rows[i];
                end
            end
            grown &= ~seen;
            seen |= grown;
            front = grown;
        end
        ans.reached_mask = seen;
        ans.reached_count = COUNT_W'($countones(seen));
        return ans;
    endfunction

    task automatic record_stop(t_req r);
        if (r.node >= NODES) begin
            last_stop_valid = 1'b0;
        end else begin
            if (!r.line_start && last_stop_valid) begin
                link_rows[r.node][last_stop] = 1'b1;
                link_rows[last_stop][r.node] = 1'b1;
            end
            last_stop = r.node;
            last_stop_valid = 1'b1;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_req(t_req r, bit typed, t_rsp typed_answer);
        t_rsp expected;
        req_if.payload = r;
        req_if.valid = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        if (r.func == FUNC_QUERY) begin
            expected = typed ? typed_answer : reach_within(r.node, r.hop_limit);
            pending_answers = {pending_answers, expected};
        end else begin
            record_stop(r);
        end
        sent++;
        @(negedge i_clk);
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                req_if.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_random_query();
        t_req r;
        r.func = FUNC_QUERY;
        r.node = NODE_W'($urandom_range(0, NODES - 1));
        r.line_start = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r.hop_limit = LIMIT_W'($urandom_range(0, 6));
            5, 6:          r.hop_limit = LIMIT_W'($urandom_range(7, 70));
            7, 8:          r.hop_limit = LIMIT_W'($urandom);
            default:       r.hop_limit = LIMIT_W'($urandom_range(NODES - 3, NODES + 1));
        endcase
        send_req(r, 1'b0, '0);
        pace();
    endtask

    // Lines are drawn from a window that drifts over the node range, which keeps the graph
    // sparse and long enough for deep hop counts.
    task automatic send_random_line();
        t_req r;
        int   len;
        int   base;
        len = $urandom_range(2, 7);
        base = (sent / 12) % NODES;
        for (int i = 0; i < len; i++) begin
            r.func = FUNC_STOP;
            r.line_start = (i == 0);
            r.hop_limit = LIMIT_W'($urandom);
            if (i > 0 && $urandom_range(0, 9) == 0) begin
                r.node = last_stop;
            end else begin
                r.node = NODE_W'((base + $urandom_range(0, 15)) % NODES);
            end
            send_req(r, 1'b0, '0);
            pace();
        end
    endtask

    task automatic send_noise();
        t_req r;
        r.func = FUNC_STOP;
        r.node = NODE_W'($urandom_range(0, NODES - 1));
        r.line_start = 1'($urandom_range(0, 1));
        r.hop_limit = LIMIT_W'($urandom);
        send_req(r, 1'b0, '0);
        pace();
    endtask

    initial begin
        t_req r;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        errors = 0;
        sent = 0;
        burst_left = 0;
        hold_off_req = 1'b0;
        last_stop = '0;
        last_stop_valid = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            link_rows[i] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[i]) begin
            send_req(script[i].req, script[i].typed, script[i].answer);
            pace();
        end

        // The receiver holds off while queries keep coming, so the block backs up.
        hold_off_req = 1'b1;
        for (int i = 0; i < 20; i++) begin
            r.func = FUNC_QUERY;
            r.node = NODE_W'($urandom_range(0, NODES - 1));
            r.line_start = 1'b0;
            r.hop_limit = LIMIT_W'($urandom_range(0, 8));
            send_req(r, 1'b0, '0);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2:       send_random_line();
                3, 4, 5, 6, 7: send_random_query();
                default:       send_noise();
            endcase
        end

        req_if.valid = 1'b0;
        wait (pending_answers.size() == 0);
        repeat (NODES + 8) @(posedge i_clk);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                rsp_if.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 40);
            end
            mode_left--;
            case (mode)
                0:       rsp_if.ready = 1'b1;
                1:       rsp_if.ready = ($urandom_range(0, 9) < 7);
                default: rsp_if.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual mask %h count %0d",
                         $time, rsp_if.payload.reached_mask, rsp_if.payload.reached_count);
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (rsp_if.payload.reached_mask !== oldest_answer.reached_mask) begin
                    errors++;
                    $display("%0t: reached_mask expected %h actual %h", $time,
                             oldest_answer.reached_mask, rsp_if.payload.reached_mask);
                end
                if (rsp_if.payload.reached_count !== oldest_answer.reached_count) begin
                    errors++;
                    $display("%0t: reached_count expected %0d actual %0d", $time,
                             oldest_answer.reached_count, rsp_if.payload.reached_count);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
